// ===== hdl/qph_pkg.sv =====
// Shared types and constants for the quadratic probing hash table.
// Used by every module of the block and by its checker; depends on nothing.
package qph_pkg;

    localparam int unsigned TABLE_SIZE  = 11;
    localparam int unsigned VALUE_W     = 31;
    localparam int unsigned SLOT_W      = $clog2(TABLE_SIZE);
    localparam int unsigned COUNT_W     = $clog2(TABLE_SIZE + 1);
    localparam int unsigned STATUS_W    = 3;
    localparam int unsigned POS_W       = 4;
    localparam int unsigned CNT_OUT_W   = 4;

    // Reciprocal of the table size for the home slot remainder.
    localparam int unsigned RECIP_SHIFT = 34;
    localparam logic [RECIP_SHIFT-1:0] RECIP =
        RECIP_SHIFT'((65'd1 << RECIP_SHIFT) / TABLE_SIZE);

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_NO_SLOT   = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_SEARCH = 1'b1
    } op_t;

    typedef struct packed {
        status_t              status;
        logic [SLOT_W-1:0]    slot;
        logic [COUNT_W-1:0]   count;
    } result_t;

    typedef struct packed {
        logic                 wr_en;
        logic [SLOT_W-1:0]    wr_addr;
        logic [SLOT_W-1:0]    rd_addr;
    } mem_req_t;

endpackage

// ===== hdl/qph_home_calc.sv =====
// Three-stage remainder unit: home slot = value mod table size.
// Depends on qph_pkg for the table size and the reciprocal constant.
module qph_home_calc (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [qph_pkg::VALUE_W-1:0] value,
    output logic                        done,
    output logic [qph_pkg::SLOT_W-1:0]  home
);

    logic [2:0]                                   stage_vld_reg;
    logic [qph_pkg::VALUE_W-1:0]                  val1_reg;
    logic [qph_pkg::VALUE_W-1:0]                  quot_reg;
    logic [qph_pkg::SLOT_W:0]                     diff_reg;
    logic [qph_pkg::SLOT_W-1:0]                   home_reg;
    logic [qph_pkg::VALUE_W+qph_pkg::RECIP_SHIFT-1:0] product;
    logic [qph_pkg::VALUE_W-1:0]                  quot_times_n;
    logic [qph_pkg::VALUE_W-1:0]                  diff_full;
    logic [qph_pkg::SLOT_W:0]                     home_next;

    // The estimated quotient is low by at most one, so the raw remainder
    // stays below twice the table size and one subtract corrects it.
    assign product      = value * qph_pkg::RECIP;
    assign quot_times_n = quot_reg * qph_pkg::VALUE_W'(qph_pkg::TABLE_SIZE);
    assign diff_full    = val1_reg - quot_times_n;
    assign home_next    = (diff_reg >= (qph_pkg::SLOT_W+1)'(qph_pkg::TABLE_SIZE)) ?
                          diff_reg - (qph_pkg::SLOT_W+1)'(qph_pkg::TABLE_SIZE) : diff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_vld_reg <= '0;
        end
        else
        begin
            stage_vld_reg <= {stage_vld_reg[1:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        val1_reg <= value;
        quot_reg <= product[qph_pkg::RECIP_SHIFT +: qph_pkg::VALUE_W];
        diff_reg <= diff_full[qph_pkg::SLOT_W:0];
        home_reg <= home_next[qph_pkg::SLOT_W-1:0];
    end

    assign done = stage_vld_reg[2];
    assign home = home_reg;

endmodule

// ===== hdl/qph_value_store.sv =====
// Slot value memory: one write port, one read port, registered read data.
// Depends on qph_pkg for the table depth and the value width.
module qph_value_store (
    input  logic                        clk,
    input  qph_pkg::mem_req_t           req,
    input  logic [qph_pkg::VALUE_W-1:0] wr_data,
    output logic [qph_pkg::VALUE_W-1:0] rd_data
);

    logic [qph_pkg::VALUE_W-1:0] mem [qph_pkg::TABLE_SIZE];
    logic [qph_pkg::VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[req.rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/qph_probe_seq.sv =====
// Probe sequencer: walks the quadratic probe path, keeps the valid bits
// and the occupancy count. Depends on qph_pkg.
module qph_probe_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        start_op,
    input  logic [qph_pkg::VALUE_W-1:0] start_value,
    output logic                        busy,
    output logic                        hash_start,
    input  logic                        hash_done,
    input  logic [qph_pkg::SLOT_W-1:0]  hash_home,
    output qph_pkg::mem_req_t           mem_req,
    output logic [qph_pkg::VALUE_W-1:0] mem_wr_data,
    input  logic [qph_pkg::VALUE_W-1:0] mem_rd_data,
    input  logic                        out_free,
    output logic                        res_load,
    output qph_pkg::result_t            res
);

    localparam int unsigned SW = qph_pkg::SLOT_W;
    localparam int unsigned CW = qph_pkg::COUNT_W;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_HASH   = 4'b0010,
        S_PROBE  = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t                          state_reg, state_next;
    qph_pkg::op_t                    op_reg;
    logic [qph_pkg::VALUE_W-1:0]     value_reg;
    logic [SW-1:0]                   home_reg, home_next;
    logic [SW-1:0]                   offset_reg, offset_next;
    logic [SW-1:0]                   step_reg, step_next;
    logic [CW-1:0]                   iter_reg, iter_next;
    logic [qph_pkg::TABLE_SIZE-1:0]  valid_reg, valid_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic                            cmp_vld_reg, cmp_vld_next;
    logic [SW-1:0]                   cmp_slot_reg, cmp_slot_next;
    qph_pkg::result_t                res_reg, res_next;
    logic                            mem_wr;

    logic [SW:0]                     slot_sum, offset_sum, step_sum;
    logic [SW-1:0]                   slot;
    logic                            slot_used;
    logic                            wrapped;
    logic                            match;

    assign slot_sum   = {1'b0, home_reg} + {1'b0, offset_reg};
    assign slot       = (slot_sum >= (SW+1)'(qph_pkg::TABLE_SIZE)) ?
                        SW'(slot_sum - (SW+1)'(qph_pkg::TABLE_SIZE)) : slot_sum[SW-1:0];
    assign offset_sum = {1'b0, offset_reg} + {1'b0, step_reg};
    assign step_sum   = {1'b0, step_reg} + (SW+1)'(2);
    assign slot_used  = valid_reg[slot];
    assign wrapped    = (iter_reg != '0) && (offset_reg == '0);
    assign match      = cmp_vld_reg && (mem_rd_data == value_reg);

    always_comb
    begin
        state_next    = state_reg;
        home_next     = home_reg;
        offset_next   = offset_reg;
        step_next     = step_reg;
        iter_next     = iter_reg;
        valid_next    = valid_reg;
        count_next    = count_reg;
        cmp_vld_next  = 1'b0;
        cmp_slot_next = cmp_slot_reg;
        res_next      = res_reg;
        mem_wr        = 1'b0;
        res_load      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    home_next   = hash_home;
                    offset_next = '0;
                    step_next   = SW'(1);
                    iter_next   = '0;
                    if ((op_reg == qph_pkg::OP_INSERT) &&
                        (count_reg == CW'(qph_pkg::TABLE_SIZE)))
                    begin
                        res_next   = '{qph_pkg::ST_FULL, '0, count_reg};
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_PROBE;
                    end
                end
            end
            S_PROBE:
            begin
                if (op_reg == qph_pkg::OP_INSERT)
                begin
                    priority if (!slot_used)
                    begin
                        valid_next[slot] = 1'b1;
                        mem_wr           = 1'b1;
                        count_next       = count_reg + CW'(1);
                        res_next         = '{qph_pkg::ST_INSERTED, slot, count_reg + CW'(1)};
                        state_next       = S_FINISH;
                    end
                    else if (iter_reg == CW'(qph_pkg::TABLE_SIZE - 1))
                    begin
                        res_next   = '{qph_pkg::ST_NO_SLOT, '0, count_reg};
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        iter_next = iter_reg + CW'(1);
                    end
                end
                else
                begin
                    // The compare of the previous probe wins over the stop
                    // conditions seen at the probe being issued now.
                    priority if (match)
                    begin
                        res_next   = '{qph_pkg::ST_FOUND, cmp_slot_reg, count_reg};
                        state_next = S_FINISH;
                    end
                    else if (wrapped || !slot_used)
                    begin
                        res_next   = '{qph_pkg::ST_NOT_FOUND, '0, count_reg};
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cmp_vld_next  = 1'b1;
                        cmp_slot_next = slot;
                        iter_next     = iter_reg + CW'(1);
                    end
                end
                offset_next = (offset_sum >= (SW+1)'(qph_pkg::TABLE_SIZE)) ?
                              SW'(offset_sum - (SW+1)'(qph_pkg::TABLE_SIZE)) :
                              offset_sum[SW-1:0];
                step_next   = (step_sum >= (SW+1)'(qph_pkg::TABLE_SIZE)) ?
                              SW'(step_sum - (SW+1)'(qph_pkg::TABLE_SIZE)) :
                              step_sum[SW-1:0];
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            count_reg   <= '0;
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            count_reg   <= count_next;
            cmp_vld_reg <= cmp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && (state_reg == S_IDLE))
        begin
            op_reg    <= qph_pkg::op_t'(start_op);
            value_reg <= start_value;
        end
        home_reg     <= home_next;
        offset_reg   <= offset_next;
        step_reg     <= step_next;
        iter_reg     <= iter_next;
        cmp_slot_reg <= cmp_slot_next;
        res_reg      <= res_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign hash_start  = start && (state_reg == S_IDLE);
    assign mem_req     = '{mem_wr, slot, slot};
    assign mem_wr_data = value_reg;
    assign res         = res_reg;

endmodule

// ===== hdl/quadratic_probe_hash_table_unit.sv =====
// Top level of the quadratic probing hash table with its result register.
// Depends on qph_pkg, qph_home_calc, qph_value_store and qph_probe_seq.
//
//  Channel   Valid      Stall      Payload
//  request   req_valid  req_stall  operation, value
//  response  rsp_valid  rsp_stall  status, position, stored_count
//
// One item is worked on at a time. The home stages compute the home slot, the probe state
// then reads one slot per probe (a search also compares its last read), and the finish
// state loads the result; the request side reopens in the cycle after the load. Reset
// clears the valid bits, the occupancy count and the handshake state, not the value
// memory. A stalled result holds the output register while the next item is accepted;
// only that item's result waits.
module quadratic_probe_hash_table_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic                          operation,
    input  logic [qph_pkg::VALUE_W-1:0]   value,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [qph_pkg::STATUS_W-1:0]  status,
    output logic [qph_pkg::POS_W-1:0]     position,
    output logic [qph_pkg::CNT_OUT_W-1:0] stored_count
);

    logic                          busy;
    logic                          accept;
    logic                          hash_start;
    logic                          hash_done;
    logic [qph_pkg::SLOT_W-1:0]    hash_home;
    qph_pkg::mem_req_t             mem_req;
    logic [qph_pkg::VALUE_W-1:0]   mem_wr_data;
    logic [qph_pkg::VALUE_W-1:0]   mem_rd_data;
    logic                          out_free;
    logic                          res_load;
    qph_pkg::result_t              res;

    logic                          rsp_valid_reg, rsp_valid_next;
    logic [qph_pkg::STATUS_W-1:0]  status_reg;
    logic [qph_pkg::POS_W-1:0]     position_reg;
    logic [qph_pkg::CNT_OUT_W-1:0] count_reg;

    // The request side is open whenever the sequencer is idle; a waiting
    // result does not hold it off.
    assign req_stall = busy;
    assign accept    = req_valid && !busy;

    // The output register can take a new result when empty or being drained.
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    qph_home_calc u_home (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .value (value),
        .done  (hash_done),
        .home  (hash_home)
    );

    // Writes (inserts) and reads (searches) of the value memory never
    // belong to overlapping items: each item passes the home stages before
    // it probes, so no forwarding path is needed.
    qph_value_store u_store (
        .clk     (clk),
        .req     (mem_req),
        .wr_data (mem_wr_data),
        .rd_data (mem_rd_data)
    );

    qph_probe_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (accept),
        .start_op    (operation),
        .start_value (value),
        .busy        (busy),
        .hash_start  (hash_start),
        .hash_done   (hash_done),
        .hash_home   (hash_home),
        .mem_req     (mem_req),
        .mem_wr_data (mem_wr_data),
        .mem_rd_data (mem_rd_data),
        .out_free    (out_free),
        .res_load    (res_load),
        .res         (res)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        priority if (res_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            status_reg   <= res.status;
            position_reg <= qph_pkg::POS_W'(res.slot);
            count_reg    <= qph_pkg::CNT_OUT_W'(res.count);
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign status       = status_reg;
    assign position     = position_reg;
    assign stored_count = count_reg;

endmodule

// ===== hdl/qph_checker.sv =====
// Port-level checker for the quadratic probing hash table, with its bind.
// Depends on qph_pkg and on the top level's port names.
module qph_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_stall,
    input logic                          rsp_valid,
    input logic                          rsp_stall,
    input logic [qph_pkg::STATUS_W-1:0]  status,
    input logic [qph_pkg::POS_W-1:0]     position,
    input logic [qph_pkg::CNT_OUT_W-1:0] stored_count
);

    // A stalled result holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(status) &&
        $stable(position) && $stable(stored_count))
        else $error("stalled result changed");

    // Only one item is in work: an accepted item closes the request side.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request side open right after an accept");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == qph_pkg::ST_FULL) |->
        stored_count == qph_pkg::CNT_OUT_W'(qph_pkg::TABLE_SIZE))
        else $error("table full reported below capacity");

    a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && ((status == qph_pkg::ST_FULL) || (status == qph_pkg::ST_NO_SLOT) ||
        (status == qph_pkg::ST_NOT_FOUND)) |-> position == '0)
        else $error("position set on a miss");

    a_hit_pos: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && ((status == qph_pkg::ST_INSERTED) || (status == qph_pkg::ST_FOUND)) |->
        (position < qph_pkg::POS_W'(qph_pkg::TABLE_SIZE)) && (stored_count != '0))
        else $error("hit with bad position or empty table");

endmodule

bind quadratic_probe_hash_table_unit qph_checker u_qph_checker (.*);
